// ===== design/sfip_pkg.sv =====
package sfip_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int FIFO_DEPTH_DEF = 4;

   // derived widths
   localparam int W  = COORD_WIDTH;
   localparam int RW = W + 1;          // coordinate differences
   localparam int PW = 2 * RW;         // one product of two differences
   localparam int CW = 2 * W + 4;      // cross and dot product sums
   localparam int DW = 2 * W + 2;      // divisor magnitude
   localparam int NW = W + DW + 2;     // numerator
   localparam int AW = W + DW;         // numerator magnitude

   typedef logic signed [W-1:0]  coord_type;
   typedef logic signed [RW-1:0] diff_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [CW-1:0] sum_type;
   typedef logic        [DW-1:0] div_type;
   typedef logic signed [NW-1:0] num_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_CROSS   = 2'd1,
      KIND_OVERLAP = 2'd2
   } hit_kind_type;

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_end_x;
      coord_type b_end_y;
   } req_type;

   typedef struct packed {
      logic         hit;
      hit_kind_type hit_kind;
      coord_type    point_x;
      coord_type    point_y;
   } rsp_type;

   // one classified item: point = num / div on each axis
   typedef struct packed {
      hit_kind_type kind;
      num_type      num_x;
      num_type      num_y;
      div_type      div;
   } work_type;

endpackage

// ===== design/sfip_front.sv =====
module sfip_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sfip_pkg::req_type req,
   input  logic              q_full,
   output logic              q_push,
   output sfip_pkg::work_type q_data
);
   import sfip_pkg::*;

   localparam int NSTG = 7;

   logic            adv;
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;

   // stage 1: differences
   coord_type px1_ff, py1_ff;
   diff_type  rx1_ff, ry1_ff, sx1_ff, sy1_ff, dx1_ff, dy1_ff;
   diff_type  rx1_in, ry1_in, sx1_in, sy1_in, dx1_in, dy1_in;
   // stage 2: products
   coord_type px2_ff, py2_ff;
   diff_type  rx2_ff, ry2_ff;
   prod_type  rxsy2_ff, rysx2_ff, dxry2_ff, dyrx2_ff, dxsy2_ff, dysx2_ff;
   prod_type  rxrx2_ff, ryry2_ff, dxrx2_ff, dyry2_ff, sxrx2_ff, syry2_ff;
   // stage 3: sums
   coord_type px3_ff, py3_ff;
   diff_type  rx3_ff, ry3_ff;
   sum_type   den3_ff, un3_ff, tn3_ff, rr3_ff, a03_ff, a13_ff;
   sum_type   den3_in, un3_in, tn3_in, rr3_in, a03_in, a13_in;
   // stage 4: sign fix and compares
   coord_type px4_ff, py4_ff;
   diff_type  rx4_ff, ry4_ff;
   sum_type   den4_ff, un4_ff, tn4_ff, rr4_ff, a04_ff, a14_ff;
   sum_type   den4_in, un4_in, tn4_in;
   logic      den_nz_ff, un_z_ff, rr_nz_ff;
   logic      a0_lt0_ff, a0_gt_rr_ff, a1_ge0_ff, a1_le_rr_ff, a0_lt_a1_ff, a1_lt0_ff;
   // stage 5: case selection
   logic      in_rng;
   sum_type   m_sel;
   logic      m_neg;
   hit_kind_type kind5_ff, kind5_in;
   div_type   dv5_ff, dv5_in, mv5_ff, mv5_in;
   coord_type px5_ff, py5_ff, px5_in, py5_in;
   diff_type  rx5_ff, ry5_ff;
   // stage 6: scaled products
   hit_kind_type kind6_ff;
   div_type   dv6_ff;
   logic signed [W+DW:0] pdx6_ff, pdy6_ff, pdx6_in, pdy6_in;
   num_type   rmx6_ff, rmy6_ff, rmx6_in, rmy6_in;
   // stage 7: numerators
   hit_kind_type kind7_ff;
   div_type   dv7_ff;
   num_type   numx7_ff, numy7_ff;

   assign adv       = !q_full;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[NSTG-2:0], req_valid};
   assign q_push    = adv && vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign rx1_in = diff_type'(req.a_end_x) - diff_type'(req.a_start_x);
   assign ry1_in = diff_type'(req.a_end_y) - diff_type'(req.a_start_y);
   assign sx1_in = diff_type'(req.b_end_x) - diff_type'(req.b_start_x);
   assign sy1_in = diff_type'(req.b_end_y) - diff_type'(req.b_start_y);
   assign dx1_in = diff_type'(req.b_start_x) - diff_type'(req.a_start_x);
   assign dy1_in = diff_type'(req.b_start_y) - diff_type'(req.a_start_y);

   assign den3_in = sum_type'(rxsy2_ff) - sum_type'(rysx2_ff);
   assign un3_in  = sum_type'(dxry2_ff) - sum_type'(dyrx2_ff);
   assign tn3_in  = sum_type'(dxsy2_ff) - sum_type'(dysx2_ff);
   assign rr3_in  = sum_type'(rxrx2_ff) + sum_type'(ryry2_ff);
   assign a03_in  = sum_type'(dxrx2_ff) + sum_type'(dyry2_ff);
   assign a13_in  = sum_type'(dxrx2_ff) + sum_type'(dyry2_ff)
                  + sum_type'(sxrx2_ff) + sum_type'(syry2_ff);

   // make the denominator positive, negating t and u numerators with it
   assign den4_in = den3_ff[CW-1] ? -den3_ff : den3_ff;
   assign un4_in  = den3_ff[CW-1] ? -un3_ff  : un3_ff;
   assign tn4_in  = den3_ff[CW-1] ? -tn3_ff  : tn3_ff;

   assign in_rng = !un4_ff[CW-1] && (un4_ff <= den4_ff)
                && !tn4_ff[CW-1] && (tn4_ff <= den4_ff);
   assign m_sel  = a0_lt_a1_ff ? a04_ff : a14_ff;
   assign m_neg  = a0_lt_a1_ff ? a0_lt0_ff : a1_lt0_ff;

   // endpoint hits use div 1 and mult 0 (start) or 1 (end); no hit gives 0/1
   always_comb begin
      kind5_in = KIND_NONE;
      dv5_in   = div_type'(1);
      mv5_in   = '0;
      px5_in   = '0;
      py5_in   = '0;
      if (den_nz_ff) begin
         if (in_rng) begin
            kind5_in = KIND_CROSS;
            dv5_in   = den4_ff[DW-1:0];
            mv5_in   = tn4_ff[DW-1:0];
            px5_in   = px4_ff;
            py5_in   = py4_ff;
         end
      end else if (un_z_ff && rr_nz_ff) begin
         if (a0_lt0_ff) begin
            if (a1_ge0_ff) begin
               kind5_in = KIND_OVERLAP;
               px5_in   = px4_ff;
               py5_in   = py4_ff;
            end
         end else if (a0_gt_rr_ff) begin
            if (a1_le_rr_ff) begin
               kind5_in = KIND_OVERLAP;
               mv5_in   = div_type'(1);
               px5_in   = px4_ff;
               py5_in   = py4_ff;
            end
         end else begin
            kind5_in = KIND_OVERLAP;
            dv5_in   = rr4_ff[DW-1:0];
            mv5_in   = m_neg ? '0 : m_sel[DW-1:0];
            px5_in   = px4_ff;
            py5_in   = py4_ff;
         end
      end
   end

   assign pdx6_in = px5_ff * $signed({1'b0, dv5_ff});
   assign pdy6_in = py5_ff * $signed({1'b0, dv5_ff});
   assign rmx6_in = rx5_ff * $signed({1'b0, mv5_ff});
   assign rmy6_in = ry5_ff * $signed({1'b0, mv5_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         px1_ff <= req.a_start_x;
         py1_ff <= req.a_start_y;
         rx1_ff <= rx1_in;
         ry1_ff <= ry1_in;
         sx1_ff <= sx1_in;
         sy1_ff <= sy1_in;
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;

         px2_ff   <= px1_ff;
         py2_ff   <= py1_ff;
         rx2_ff   <= rx1_ff;
         ry2_ff   <= ry1_ff;
         rxsy2_ff <= rx1_ff * sy1_ff;
         rysx2_ff <= ry1_ff * sx1_ff;
         dxry2_ff <= dx1_ff * ry1_ff;
         dyrx2_ff <= dy1_ff * rx1_ff;
         dxsy2_ff <= dx1_ff * sy1_ff;
         dysx2_ff <= dy1_ff * sx1_ff;
         rxrx2_ff <= rx1_ff * rx1_ff;
         ryry2_ff <= ry1_ff * ry1_ff;
         dxrx2_ff <= dx1_ff * rx1_ff;
         dyry2_ff <= dy1_ff * ry1_ff;
         sxrx2_ff <= sx1_ff * rx1_ff;
         syry2_ff <= sy1_ff * ry1_ff;

         px3_ff  <= px2_ff;
         py3_ff  <= py2_ff;
         rx3_ff  <= rx2_ff;
         ry3_ff  <= ry2_ff;
         den3_ff <= den3_in;
         un3_ff  <= un3_in;
         tn3_ff  <= tn3_in;
         rr3_ff  <= rr3_in;
         a03_ff  <= a03_in;
         a13_ff  <= a13_in;

         px4_ff      <= px3_ff;
         py4_ff      <= py3_ff;
         rx4_ff      <= rx3_ff;
         ry4_ff      <= ry3_ff;
         den4_ff     <= den4_in;
         un4_ff      <= un4_in;
         tn4_ff      <= tn4_in;
         rr4_ff      <= rr3_ff;
         a04_ff      <= a03_ff;
         a14_ff      <= a13_ff;
         den_nz_ff   <= (den3_ff != '0);
         un_z_ff     <= (un3_ff == '0);
         rr_nz_ff    <= (rr3_ff != '0);
         a0_lt0_ff   <= a03_ff[CW-1];
         a0_gt_rr_ff <= (a03_ff > rr3_ff);
         a1_ge0_ff   <= !a13_ff[CW-1];
         a1_le_rr_ff <= (a13_ff <= rr3_ff);
         a0_lt_a1_ff <= (a03_ff < a13_ff);
         a1_lt0_ff   <= a13_ff[CW-1];

         kind5_ff <= kind5_in;
         dv5_ff   <= dv5_in;
         mv5_ff   <= mv5_in;
         px5_ff   <= px5_in;
         py5_ff   <= py5_in;
         rx5_ff   <= rx4_ff;
         ry5_ff   <= ry4_ff;

         kind6_ff <= kind5_ff;
         dv6_ff   <= dv5_ff;
         pdx6_ff  <= pdx6_in;
         pdy6_ff  <= pdy6_in;
         rmx6_ff  <= rmx6_in;
         rmy6_ff  <= rmy6_in;

         kind7_ff <= kind6_ff;
         dv7_ff   <= dv6_ff;
         numx7_ff <= num_type'(pdx6_ff) + rmx6_ff;
         numy7_ff <= num_type'(pdy6_ff) + rmy6_ff;
      end
   end

   assign q_data.kind  = kind7_ff;
   assign q_data.num_x = numx7_ff;
   assign q_data.num_y = numy7_ff;
   assign q_data.div   = dv7_ff;

endmodule

// ===== design/sfip_fifo.sv =====
module sfip_fifo #(
   parameter int DEPTH = sfip_pkg::FIFO_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sfip_pkg::work_type push_data,
   input  logic               pop,
   output sfip_pkg::work_type pop_data,
   output logic               full,
   output logic               empty
);
   import sfip_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/sfip_back.sv =====
module sfip_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   output logic               q_pop,
   input  sfip_pkg::work_type q_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sfip_pkg::rsp_type  rsp
);
   import sfip_pkg::*;

   localparam int NS = W;   // one quotient bit per stage

   logic            adv;
   logic [NS:0]     vld_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff, rsp_in;

   hit_kind_type    kind_ff [NS+1];
   div_type         div_ff  [NS+1];
   logic            neg_ff  [NS+1][2];
   div_type         rem_ff  [NS+1][2];
   logic [W-1:0]    low_ff  [NS+1][2];
   logic [W-1:0]    quo_ff  [NS+1][2];
   logic            neg_in  [NS+1][2];
   div_type         rem_in  [NS+1][2];
   logic [W-1:0]    low_in  [NS+1][2];
   logic [W-1:0]    quo_in  [NS+1][2];

   num_type         num  [2];
   num_type         mag  [2];
   coord_type       pt   [2];

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign q_pop     = adv && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign num[0] = q_data.num_x;
   assign num[1] = q_data.num_y;

   // entry: magnitude split into the high part (already below div) and
   // the low bits that get shifted in one per stage
   for (genvar l = 0; l < 2; l++) begin : g_entry
      assign mag[l]       = num[l][NW-1] ? -num[l] : num[l];
      assign neg_in[0][l] = num[l][NW-1];
      assign rem_in[0][l] = mag[l][AW-1:W];
      assign low_in[0][l] = mag[l][W-1:0];
      assign quo_in[0][l] = '0;
   end

   for (genvar i = 1; i <= NS; i++) begin : g_step
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [DW:0] trial;
         logic [DW:0] diff;
         logic        ge;
         assign trial = {rem_ff[i-1][l], low_ff[i-1][l][W-1]};
         assign diff  = trial - {1'b0, div_ff[i-1]};
         assign ge    = (trial >= {1'b0, div_ff[i-1]});
         assign neg_in[i][l] = neg_ff[i-1][l];
         assign rem_in[i][l] = ge ? diff[DW-1:0] : trial[DW-1:0];
         assign low_in[i][l] = {low_ff[i-1][l][W-2:0], 1'b0};
         assign quo_in[i][l] = {quo_ff[i-1][l][W-2:0], ge};
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_sign
      assign pt[l] = neg_ff[NS][l] ? -$signed(quo_ff[NS][l]) : $signed(quo_ff[NS][l]);
   end

   assign rsp_in.hit      = (kind_ff[NS] != KIND_NONE);
   assign rsp_in.hit_kind = kind_ff[NS];
   assign rsp_in.point_x  = pt[0];
   assign rsp_in.point_y  = pt[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[NS-1:0], q_pop};
         rsp_valid_ff <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind_ff[0] <= q_data.kind;
         div_ff[0]  <= q_data.div;
         for (int i = 1; i <= NS; i++) begin
            kind_ff[i] <= kind_ff[i-1];
            div_ff[i]  <= div_ff[i-1];
         end
         for (int i = 0; i <= NS; i++) begin
            for (int l = 0; l < 2; l++) begin
               neg_ff[i][l] <= neg_in[i][l];
               rem_ff[i][l] <= rem_in[i][l];
               low_ff[i][l] <= low_in[i][l];
               quo_ff[i][l] <= quo_in[i][l];
            end
         end
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== design/segment_first_intersection_point.sv =====
// Channel  Ports                      Direction  Content
// req      req_valid/req_ready/req    in         segments A and B, one pair per item
// rsp      rsp_valid/rsp_ready/rsp    out        hit, hit_kind, point_x, point_y
//
// One item per cycle sustained while rsp is not stalled. The path runs through
// 7 front stages, one queue slot, one entry stage, one stage per quotient bit
// of the shared-divisor divider and the output register.
// Reset clears valid bits and the queue; payload registers are not reset.
// A stalled rsp freezes the back end; the queue absorbs the front until full,
// then req_ready drops.
module segment_first_intersection_point #(
   parameter int FIFO_DEPTH = sfip_pkg::FIFO_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sfip_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sfip_pkg::rsp_type rsp
);
   import sfip_pkg::*;

   logic     q_push, q_pop, q_full, q_empty;
   work_type q_wdata, q_rdata;

   sfip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   sfip_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   sfip_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_rdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   a_hit_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.hit == (rsp.hit_kind != KIND_NONE)))
      else $error("hit flag disagrees with hit_kind");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp.hit) |-> (rsp.point_x == '0 && rsp.point_y == '0))
      else $error("no-hit item carries a nonzero point");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("queue written while full");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

endmodule
